[rtl/pol_pkg.sv]
// ----------------------------------------------------------------------------
// pol_pkg: shared types and codes for the positional ordered list
// Holds the request and response payload structs, the request and status
// codes, and the control word that is broadcast to every list cell.
// ----------------------------------------------------------------------------
`default_nettype none

package pol_pkg;

   localparam int VAL_W = 32;
   localparam int POS_W = 5;
   localparam int REQ_W = 2;
   localparam int ST_W  = 2;

   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_DUMP   = 2'd2;

   localparam logic [ST_W-1:0] ST_OK     = 2'd0;
   localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
   localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

   typedef struct packed {
      logic [REQ_W-1:0]        req_type;
      logic signed [VAL_W-1:0] value;
      logic [POS_W-1:0]        position;
   } pol_req_type;

   typedef struct packed {
      logic [ST_W-1:0]         status;
      logic signed [VAL_W-1:0] element;
      logic [POS_W-1:0]        count;
      logic                    last;
   } pol_rsp_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   // pos0 is the zero-based list position of an insert or delete.
   typedef struct packed {
      cell_op_type             op;
      logic [POS_W-1:0]        pos0;
      logic signed [VAL_W-1:0] value;
   } cell_ctrl_type;

endpackage

`default_nettype wire

[rtl/positional_ordered_list.sv]
// ----------------------------------------------------------------------------
// positional_ordered_list: bounded ordered list in a chain of shift cells
// Inserts and deletes at a one-based position and dumps the list in order.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Ports                           Moves
//   req       in         req_valid/req_ready/req_payload  one request
//   rsp       out        rsp_valid/rsp_ready/rsp_payload  one result
//
// On an insert or delete every cell shifts or holds on its own index, and
// the single result lands in the output register, both at the accept edge.
// A dump of N elements gives no result when it is accepted, then one result
// a cycle while the rsp side does not stall, read from the first cell while
// the first N cells rotate by one. After N rotations the list is back in its original order.
// Reset clears the element count and the output valid; cell contents are
// not reset. A stalled rsp side holds the output register and blocks new
// requests and further dump results until the transfer completes.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_ordered_list #(
   parameter int DEPTH = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  pol_pkg::pol_req_type req_payload,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output pol_pkg::pol_rsp_type rsp_payload
);
   import pol_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   // Control state.
   logic [CNT_W-1:0] count_ff, count_in;
   logic             dump_ff, dump_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             rsp_valid_ff, rsp_valid_in;
   // Output payload register.
   pol_rsp_type      rsp_ff, rsp_in;

   cell_ctrl_type           ctrl;
   logic signed [VAL_W-1:0] cell_q [DEPTH];
   logic [IDX_W-1:0]        last_idx;

   logic             out_free;
   logic             req_fire;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic             is_full;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !dump_ff && out_free;
   assign req_fire  = req_valid && req_ready;
   assign pos_ext   = CMP_W'(req_payload.position);
   assign cnt_ext   = CMP_W'(count_ff);
   assign is_full   = (count_ff == CNT_W'(DEPTH));
   // Highest occupied cell, used by the rotation during a dump.
   assign last_idx  = IDX_W'(count_ff - CNT_W'(1));

   always_comb begin
      count_in     = count_ff;
      dump_in      = dump_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      ctrl.op      = CELL_HOLD;
      ctrl.pos0    = req_payload.position - POS_W'(1);
      ctrl.value   = req_payload.value;

      if (req_fire) begin
         rsp_in.element = '0;
         rsp_in.last    = 1'b1;
         priority if (req_payload.req_type == REQ_INSERT) begin
            rsp_valid_in = 1'b1;
            rsp_in.count = POS_W'(count_ff);
            if (is_full) begin
               rsp_in.status = ST_FULL;
            end else if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
               rsp_in.status = ST_BADPOS;
            end else begin
               rsp_in.status = ST_OK;
               ctrl.op       = CELL_INSERT;
               count_in      = count_ff + CNT_W'(1);
               rsp_in.count  = POS_W'(count_ff + CNT_W'(1));
            end
         end else if (req_payload.req_type == REQ_DELETE) begin
            rsp_valid_in = 1'b1;
            rsp_in.count = POS_W'(count_ff);
            if (pos_ext == '0 || pos_ext > cnt_ext) begin
               rsp_in.status = ST_BADPOS;
            end else begin
               rsp_in.status = ST_OK;
               ctrl.op       = CELL_DELETE;
               count_in      = count_ff - CNT_W'(1);
               rsp_in.count  = POS_W'(count_ff - CNT_W'(1));
            end
         end else if (req_payload.req_type == REQ_DUMP) begin
            if (count_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = ST_EMPTY;
               rsp_in.count  = '0;
            end else begin
               // Results follow from the dump walk; none in this cycle.
               dump_in = 1'b1;
               left_in = count_ff;
            end
         end else begin
            // Undefined request code: taken and dropped without a result.
            rsp_in = rsp_ff;
         end
      end else if (dump_ff && out_free) begin
         // Emit the head cell and rotate the occupied cells by one.
         rsp_valid_in   = 1'b1;
         rsp_in.status  = ST_OK;
         rsp_in.element = cell_q[0];
         rsp_in.count   = POS_W'(count_ff);
         rsp_in.last    = (left_ff == CNT_W'(1));
         ctrl.op        = CELL_ROTATE;
         left_in        = left_ff - CNT_W'(1);
         if (left_ff == CNT_W'(1)) begin
            dump_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         dump_ff      <= 1'b0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         dump_ff      <= dump_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   // The cell chain. The first cell has no left neighbor and the last cell
   // no right neighbor; those inputs are never selected for a live element.
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [VAL_W-1:0] left_v;
      logic signed [VAL_W-1:0] right_v;

      if (g == 0) begin : g_first
         assign left_v = req_payload.value;
      end else begin : g_mid_l
         assign left_v = cell_q[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_v = cell_q[g];
      end else begin : g_mid_r
         assign right_v = cell_q[g+1];
      end

      pol_cell #(
         .IDX_W(IDX_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .idx        (IDX_W'(g)),
         .last_idx   (last_idx),
         .left_value (left_v),
         .right_value(right_v),
         .wrap_value (cell_q[0]),
         .value      (cell_q[g])
      );
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

[rtl/pol_cell.sv]
// ----------------------------------------------------------------------------
// pol_cell: one storage cell of the list chain
// Holds one element and picks its next value from itself, its neighbors,
// the new value or the wrap value, using only its own index.
// ----------------------------------------------------------------------------
`default_nettype none

module pol_cell #(
   parameter int IDX_W = 4
) (
   input  wire                             clock,
   input  pol_pkg::cell_ctrl_type          ctrl,
   input  wire [IDX_W-1:0]                 idx,
   input  wire [IDX_W-1:0]                 last_idx,
   input  wire signed [pol_pkg::VAL_W-1:0] left_value,
   input  wire signed [pol_pkg::VAL_W-1:0] right_value,
   input  wire signed [pol_pkg::VAL_W-1:0] wrap_value,
   output logic signed [pol_pkg::VAL_W-1:0] value
);
   import pol_pkg::*;

   localparam int CW = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1;

   logic signed [VAL_W-1:0] value_ff;
   logic signed [VAL_W-1:0] value_in;
   logic [CW-1:0]           idx_ext;
   logic [CW-1:0]           pos_ext;

   assign idx_ext = CW'(idx);
   assign pos_ext = CW'(ctrl.pos0);

   always_comb begin
      value_in = value_ff;
      unique case (ctrl.op)
         CELL_HOLD: begin
            value_in = value_ff;
         end
         CELL_INSERT: begin
            if (idx_ext == pos_ext) begin
               value_in = ctrl.value;
            end else if (idx_ext > pos_ext) begin
               value_in = left_value;
            end
         end
         CELL_DELETE: begin
            if (idx_ext >= pos_ext) begin
               value_in = right_value;
            end
         end
         CELL_ROTATE: begin
            if (idx == last_idx) begin
               value_in = wrap_value;
            end else if (idx < last_idx) begin
               value_in = right_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

[rtl/pol_checker.sv]
// ----------------------------------------------------------------------------
// pol_checker: port-level checks for the positional ordered list
// Watches the response channel for properties of the list's results.
// ----------------------------------------------------------------------------
`default_nettype none

module pol_checker (
   input wire                  clock,
   input wire                  reset,
   input wire                  rsp_valid,
   input wire                  rsp_ready,
   input pol_pkg::pol_rsp_type rsp_payload
);
   import pol_pkg::*;

   // A result offered and not taken is still offered in the next cycle.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before the transfer");

   // An empty dump reports a zero count and closes the request.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_EMPTY |->
         rsp_payload.count == '0 && rsp_payload.last)
      else $error("empty status with a nonzero count or without last");

   // Error and empty results are single results that carry no element.
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != ST_OK |->
         rsp_payload.last && rsp_payload.element == '0)
      else $error("non-ok result without last or with an element");

   // No result is offered in the first cycle after reset is released.
   a_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("rsp_valid high right after reset");

endmodule

bind positional_ordered_list pol_checker u_pol_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_payload(rsp_payload)
);

`default_nettype wire
